/* sv/etbd_pkg.sv */
`default_nettype none

package etbd_pkg;

    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'd0,
        MODE_DOLLAR = 3'd1,
        MODE_HEX    = 3'd2,
        MODE_CTRL   = 3'd3,
        MODE_BSLASH = 3'd4
    } etbd_mode_t;

    typedef struct packed {
        logic       emit;
        logic       error;
        logic [7:0] data;
    } etbd_result_t;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_ESC     = 8'h1B;

    // Returns {is_digit, value}; value is zero when the character is no hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/etbd_decode.sv */
`default_nettype none

module etbd_decode
    import etbd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   ch,
    input  wire logic         last_of_line,
    output etbd_result_t      result
);

    etbd_mode_t mode_reg, mode_next;
    logic [3:0] nibble_reg, nibble_next;
    logic       halted_reg, halted_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg   <= MODE_PLAIN;
            nibble_reg <= 4'd0;
            halted_reg <= 1'b0;
        end
        else if (step) begin
            mode_reg   <= mode_next;
            nibble_reg <= nibble_next;
            halted_reg <= halted_next;
        end
    end

    always_comb begin
        logic [4:0] hex;
        logic       bad;
        logic       emit;
        logic [7:0] byte_val;
        etbd_mode_t after;
        logic [3:0] nib;

        hex      = hex_digit(ch);
        bad      = 1'b0;
        emit     = 1'b0;
        byte_val = 8'd0;
        after    = MODE_PLAIN;
        nib      = 4'd0;

        unique case (mode_reg)
            MODE_DOLLAR: begin
                if (hex[4]) begin
                    nib   = hex[3:0];
                    after = MODE_HEX;
                end
                else if (ch == CH_DOLLAR) begin
                    byte_val = CH_DOLLAR;
                    emit     = 1'b1;
                end
                else begin
                    bad = 1'b1;
                end
            end
            MODE_HEX: begin
                if (hex[4]) begin
                    byte_val = {nibble_reg, hex[3:0]};
                    emit     = 1'b1;
                end
                else begin
                    bad = 1'b1;
                end
            end
            MODE_CTRL: begin
                // Letters of either case and '@' map to the low five bits.
                if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A)
                        || ch == CH_AT) begin
                    byte_val = {3'd0, ch[4:0]};
                    emit     = 1'b1;
                end
                else if (ch == CH_CARET) begin
                    byte_val = CH_CARET;
                    emit     = 1'b1;
                end
                else begin
                    bad = 1'b1;
                end
            end
            MODE_BSLASH: begin
                if (ch == CH_UPPER_E) begin
                    byte_val = CH_ESC;
                    emit     = 1'b1;
                end
                else if (ch == CH_BSLASH) begin
                    byte_val = CH_BSLASH;
                    emit     = 1'b1;
                end
                else begin
                    bad = 1'b1;
                end
            end
            default: begin
                if (ch == CH_DOLLAR) begin
                    after = MODE_DOLLAR;
                end
                else if (ch == CH_CARET) begin
                    after = MODE_CTRL;
                end
                else if (ch == CH_BSLASH) begin
                    after = MODE_BSLASH;
                end
                else begin
                    byte_val = ch;
                    emit     = 1'b1;
                end
            end
        endcase

        mode_next   = mode_reg;
        nibble_next = nibble_reg;
        halted_next = halted_reg;
        result      = '0;

        if (!halted_reg) begin
            if (bad) begin
                halted_next = 1'b1;
                mode_next   = MODE_PLAIN;
                nibble_next = 4'd0;
                result      = '{emit: 1'b1, error: 1'b1, data: 8'd0};
            end
            else begin
                // A line end drops any escape still in progress.
                mode_next   = last_of_line ? MODE_PLAIN : after;
                nibble_next = last_of_line ? 4'd0 : nib;
                result      = '{emit: emit, error: 1'b0, data: byte_val};
            end
        end
    end

`ifndef SYNTHESIS
    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.emit && result.error |=> halted_reg)
        else $error("error result did not halt the decoder");

    a_halted_plain: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (mode_reg == MODE_PLAIN && nibble_reg == 4'd0))
        else $error("halted decoder holds escape state");

    a_nibble_only_in_hex: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != MODE_HEX |-> nibble_reg == 4'd0)
        else $error("high nibble kept outside hex mode");

    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !result.emit)
        else $error("halted decoder produced a result");
`endif

endmodule

`default_nettype wire

/* sv/escaped_text_byte_decoder.sv */
// Escaped text byte decoder: restores raw bytes from the escaped body
// characters of a dump line.
// Input channel: in_valid/in_ready carry ch and last_of_line, one character
// per item. Output channel: out_valid/out_ready carry data_byte and error.
// Each input item gives zero or one output item; escape openers give none.
// An accepted item is held in the input register, then decoded out of it
// into the output register, which offers its result until it is taken.
// One item per cycle is sustained while the receiver keeps up; the limit
// is the single decode pass between the input and output registers.
// When the receiver stalls with a result waiting, the input register still
// drains items that give no result; otherwise in_ready drops once the input
// register is full. After an invalid escape the error item is delivered and
// all later items are accepted and discarded until reset.
// Reset empties both registers and returns the decoder to plain mode.
`default_nettype none

module escaped_text_byte_decoder
    import etbd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] ch,
    input  wire logic       last_of_line,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      data_byte,
    output logic            error
);

    logic         in_vld_reg;
    logic [7:0]   ch_reg;
    logic         last_reg;
    logic         out_vld_reg;
    logic [7:0]   data_byte_reg;
    logic         error_reg;
    logic         advance;
    etbd_result_t result;

    etbd_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .ch           (ch_reg),
        .last_of_line (last_reg),
        .result       (result)
    );

    assign advance  = in_vld_reg && (!result.emit || !out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else begin
            if (in_ready) begin
                in_vld_reg <= in_valid;
            end
            if (advance && result.emit) begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && in_ready) begin
            ch_reg   <= ch;
            last_reg <= last_of_line;
        end
        if (advance && result.emit) begin
            data_byte_reg <= result.data;
            error_reg     <= result.error;
        end
    end

    assign out_valid = out_vld_reg;
    assign data_byte = data_byte_reg;
    assign error     = error_reg;

`ifndef SYNTHESIS
    a_error_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> data_byte == 8'd0)
        else $error("error item carries a nonzero byte");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_ready |-> !(advance && result.emit))
        else $error("pending result overwritten");

    a_drain_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !out_vld_reg |-> advance)
        else $error("input register stalled with free output register");
`endif

endmodule

`default_nettype wire
